@@ rtl/sfir_pkg.sv @@
// Shared types, constants and rounding helpers of the separable FIR image filter.
package sfir_pkg;

   localparam int TAPS_DEF     = 5;
   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;
   localparam int MAX_TAPS     = 5;
   localparam int MAX_LINES    = MAX_TAPS - 1;

   localparam int POS_W   = 13;
   localparam int PIX_W   = 8;
   localparam int COEF_W  = 16;
   localparam int HV_W    = 16;
   localparam int OUT_W   = 20;
   localparam int COORD_W = 10;
   localparam int HSUM_W  = 28;
   localparam int VPROD_W = 32;
   localparam int VSUM_W  = 35;

   localparam int Q_DEPTH = 8;
   localparam int Q_AW    = 3;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_COEF0  = 3'd2;
   localparam logic [2:0] REG_COEF1  = 3'd3;
   localparam logic [2:0] REG_COEF2  = 3'd4;
   localparam logic [2:0] REG_COEF3  = 3'd5;
   localparam logic [2:0] REG_COEF4  = 3'd6;

   typedef struct packed {
      logic [POS_W-1:0]                      width;
      logic [POS_W-1:0]                      height;
      logic [MAX_TAPS-1:0][COEF_W-1:0]       coef;
   } cfg_type;

   typedef struct packed {
      logic [HV_W-1:0]                       hv;
      logic [MAX_LINES-1:0][HV_W-1:0]        cw;
      logic [COORD_W-1:0]                    col;
      logic [COORD_W-1:0]                    row;
      logic                                  last;
   } entry_type;

   // Round half up by 2^14, saturate to 16 bits signed.
   function automatic logic signed [HV_W-1:0] round_h(input logic signed [HSUM_W-1:0] s);
      logic signed [HSUM_W:0] t;
      logic signed [HSUM_W:0] q;
      t = {s[HSUM_W-1], s} + (HSUM_W+1)'(8192);
      q = t >>> 14;
      if (q > (HSUM_W+1)'(32767))
         return 16'sh7fff;
      else if (q < -(HSUM_W+1)'(32768))
         return 16'sh8000;
      else
         return q[HV_W-1:0];
   endfunction

   // Round half up by 2^14, saturate to 20 bits signed.
   function automatic logic signed [OUT_W-1:0] round_v(input logic signed [VSUM_W-1:0] s);
      logic signed [VSUM_W:0] t;
      logic signed [VSUM_W:0] q;
      t = {s[VSUM_W-1], s} + (VSUM_W+1)'(8192);
      q = t >>> 14;
      if (q > (VSUM_W+1)'(524287))
         return 20'sh7ffff;
      else if (q < -(VSUM_W+1)'(524288))
         return 20'sh80000;
      else
         return q[OUT_W-1:0];
   endfunction

endpackage

@@ rtl/sfir_front.sv @@
// Front end: position tracking, horizontal filter and line stores.
module sfir_front #(
   parameter int TAPS     = sfir_pkg::TAPS_DEF,
   parameter int MAX_COLS = sfir_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = sfir_pkg::MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfir_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sfir_pkg::PIX_W-1:0]    pixel,
   input  logic [sfir_pkg::Q_AW:0]       q_count,
   output logic                          push,
   output sfir_pkg::entry_type           push_entry
);
   localparam int LINES = TAPS - 1;
   localparam int HALF  = LINES / 2;
   localparam int LB    = $clog2(LINES);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int PW    = sfir_pkg::POS_W;
   localparam int HP_W  = sfir_pkg::COEF_W + sfir_pkg::PIX_W + 1;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [sfir_pkg::PIX_W-1:0] win_ff [LINES];

   logic [PW-1:0] col_x, row_x, col_e, row_e, col_n, row_n;
   logic accept, emit_h, emit_v, last;

   // stage 1: products
   logic s1_v_ff, s1_e_ff, s1_last_ff;
   logic [CW-1:0] s1_c_ff;
   logic [sfir_pkg::COORD_W-1:0] s1_row_ff;
   logic [LB-1:0] s1_slot_ff;
   logic signed [HP_W-1:0] s1_p_ff [TAPS];
   // stage 2: horizontal result
   logic s2_v_ff, s2_e_ff, s2_last_ff;
   logic [CW-1:0] s2_c_ff;
   logic [sfir_pkg::COORD_W-1:0] s2_row_ff;
   logic [LB-1:0] s2_slot_ff;
   logic signed [sfir_pkg::HV_W-1:0] s2_hv_ff;
   // stage 3: line store data
   logic s3_e_ff, s3_last_ff;
   logic [CW-1:0] s3_c_ff;
   logic [sfir_pkg::COORD_W-1:0] s3_row_ff;
   logic [LB-1:0] s3_slot_ff;
   logic [sfir_pkg::HV_W-1:0] s3_hv_ff;
   logic [sfir_pkg::HV_W-1:0] rd_ff [LINES];

   logic signed [sfir_pkg::HSUM_W-1:0] hsum;
   logic [2:0] inflight;

   // credit check: queue room for every emitting beat still in flight
   assign inflight   = 3'(s1_e_ff) + 3'(s2_e_ff) + 3'(s3_e_ff);
   assign req_tready = ((sfir_pkg::Q_AW+2)'(q_count) + (sfir_pkg::Q_AW+2)'(inflight))
                       < (sfir_pkg::Q_AW+2)'(sfir_pkg::Q_DEPTH);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      col_x  = PW'(col_ff);
      row_x  = PW'(row_ff);
      col_e  = (col_x >= cfg.width)  ? cfg.width  - PW'(1) : col_x;
      row_e  = (row_x >= cfg.height) ? cfg.height - PW'(1) : row_x;
      emit_h = col_e >= PW'(LINES);
      emit_v = emit_h && (row_e >= PW'(LINES));
      last   = (row_e + PW'(1) >= cfg.height) && (col_e + PW'(1) >= cfg.width);
      col_n  = col_e + PW'(1);
      row_n  = row_e;
      if (col_n >= cfg.width) begin
         col_n = '0;
         row_n = (row_e + PW'(1) >= cfg.height) ? '0 : row_e + PW'(1);
      end
      col_in = col_n[CW-1:0];
      row_in = row_n[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i + 1 < LINES; i++)
            win_ff[i] <= win_ff[i+1];
         win_ff[LINES-1] <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s1_e_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s2_e_ff <= 1'b0;
         s3_e_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept && emit_h;
         s1_e_ff <= accept && emit_v;
         s2_v_ff <= s1_v_ff;
         s2_e_ff <= s1_e_ff;
         s3_e_ff <= s2_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_c_ff    <= CW'(col_e - PW'(HALF));
      s1_row_ff  <= sfir_pkg::COORD_W'(row_e - PW'(HALF));
      s1_slot_ff <= row_e[LB-1:0];
      s1_last_ff <= last;
      for (int i = 0; i < LINES; i++)
         s1_p_ff[i] <= $signed(cfg.coef[i]) * $signed({1'b0, win_ff[i]});
      s1_p_ff[LINES] <= $signed(cfg.coef[LINES]) * $signed({1'b0, pixel});
   end

   always_comb begin
      hsum = '0;
      for (int i = 0; i < TAPS; i++)
         hsum = hsum + sfir_pkg::HSUM_W'(s1_p_ff[i]);
   end

   always_ff @(posedge clock) begin
      s2_c_ff    <= s1_c_ff;
      s2_row_ff  <= s1_row_ff;
      s2_slot_ff <= s1_slot_ff;
      s2_last_ff <= s1_last_ff;
      s2_hv_ff   <= sfir_pkg::round_h(hsum);
      s3_c_ff    <= s2_c_ff;
      s3_row_ff  <= s2_row_ff;
      s3_slot_ff <= s2_slot_ff;
      s3_last_ff <= s2_last_ff;
      s3_hv_ff   <= s2_hv_ff;
   end

   // one store per line: each reads old value; slot's store writes new one
   for (genvar l = 0; l < LINES; l++) begin : g_line
      logic [sfir_pkg::HV_W-1:0] mem [MAX_COLS];
      always_ff @(posedge clock) begin
         if (s2_v_ff) begin
            rd_ff[l] <= mem[s2_c_ff];
            if (s2_slot_ff == LB'(l))
               mem[s2_c_ff] <= s2_hv_ff;
         end
      end
   end

   always_comb begin
      push_entry      = '0;
      push_entry.hv   = s3_hv_ff;
      push_entry.col  = sfir_pkg::COORD_W'(s3_c_ff);
      push_entry.row  = s3_row_ff;
      push_entry.last = s3_last_ff;
      for (int i = 0; i < LINES; i++)
         push_entry.cw[i] = rd_ff[LB'(s3_slot_ff + LB'(i))];
   end
   assign push = s3_e_ff;

endmodule

@@ rtl/sfir_queue.sv @@
// Small queue between the front and back ends.
module sfir_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  sfir_pkg::entry_type               push_entry,
   input  logic                              pop,
   output logic                              not_empty,
   output sfir_pkg::entry_type               head,
   output logic [sfir_pkg::Q_AW:0]           count
);
   sfir_pkg::entry_type mem_ff [sfir_pkg::Q_DEPTH];
   logic [sfir_pkg::Q_AW-1:0] wp_ff, rp_ff;
   logic [sfir_pkg::Q_AW:0]   cnt_ff;

   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rp_ff];
   assign count     = cnt_ff;

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wp_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push)
            wp_ff <= wp_ff + 1'b1;
         if (pop)
            rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (sfir_pkg::Q_AW+1)'(push) - (sfir_pkg::Q_AW+1)'(pop);
      end
   end

endmodule

@@ rtl/sfir_back.sv @@
// Back end: vertical filter and output register.
module sfir_back #(
   parameter int TAPS = sfir_pkg::TAPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sfir_pkg::cfg_type                 cfg,
   input  logic                              not_empty,
   input  sfir_pkg::entry_type               head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,
   output logic                              rsp_tlast
);
   localparam int LINES = TAPS - 1;

   logic v1_ff, v2_ff, adv2, adv1;
   logic signed [sfir_pkg::VPROD_W-1:0] p_ff [TAPS];
   logic [sfir_pkg::COORD_W-1:0] col1_ff, row1_ff, col2_ff, row2_ff;
   logic last1_ff, last2_ff;
   logic signed [sfir_pkg::OUT_W-1:0] val2_ff;
   logic signed [sfir_pkg::VSUM_W-1:0] vsum;

   assign adv2 = !v2_ff || rsp_tready;
   assign adv1 = !v1_ff || adv2;
   assign pop  = not_empty && adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1)
            v1_ff <= pop;
         if (adv2)
            v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         col1_ff  <= head.col;
         row1_ff  <= head.row;
         last1_ff <= head.last;
         for (int i = 0; i < LINES; i++)
            p_ff[i] <= $signed(cfg.coef[i]) * $signed(head.cw[i]);
         p_ff[LINES] <= $signed(cfg.coef[LINES]) * $signed(head.hv);
      end
   end

   always_comb begin
      vsum = '0;
      for (int i = 0; i < TAPS; i++)
         vsum = vsum + sfir_pkg::VSUM_W'(p_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         val2_ff  <= sfir_pkg::round_v(vsum);
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         last2_ff <= last1_ff;
      end
   end

   assign rsp_tvalid = v2_ff;
   assign rsp_tdata  = {row2_ff, col2_ff, val2_ff};
   assign rsp_tlast  = last2_ff;

endmodule

@@ rtl/separable_fir_image_filter_unit.sv @@
// Top level of the separable FIR image filter: register port and front/back ends.
//
// Usage: send 8-bit grayscale pixels in raster order on the req_ stream, one
// per beat. Each pixel is filtered along its row by the taps, then down its
// column; once a full window is present every input beat yields one interior
// output beat on rsp_ with the filtered value and its column and row. Border
// pixels yield nothing. rsp_tlast marks the final interior pixel of a frame.
// Path: an accepted input passes three front stages, one queue write and two
// back stages before its output beat is valid.
// Throughput: one pixel per cycle while req_tready is high; each line store is read
// at most once per pixel, and only the store of the current row slot is written.
// Reset clears the position counters, queue and valid flags; registers take
// width 640, height 480, all taps 3277. Line stores are not cleared.
// When the receiver stalls, the output register holds its beat and the back
// end stops popping once its stages are full; the front keeps accepting until
// the eight-entry queue plus beats in flight would overflow, then drops req_tready.
// Write image size and taps only while the block is idle.
module separable_fir_image_filter_unit #(
   parameter int TAPS     = sfir_pkg::TAPS_DEF,
   parameter int MAX_COLS = sfir_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = sfir_pkg::MAX_ROWS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] pixel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,    // [19:0] out_value, [29:20] out_col, [39:30] out_row
   output logic         rsp_tlast,    // frame_last
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int PW = sfir_pkg::POS_W;

   logic [10:0] width_ff, height_ff;
   logic [sfir_pkg::MAX_TAPS-1:0][sfir_pkg::COEF_W-1:0] coef_ff;
   logic [2:0] idx;
   logic wr;
   sfir_pkg::cfg_type cfg;

   logic push, pop, not_empty;
   sfir_pkg::entry_type push_entry, head;
   logic [sfir_pkg::Q_AW:0] q_count;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         for (int i = 0; i < sfir_pkg::MAX_TAPS; i++)
            coef_ff[i] <= 16'd3277;
      end else if (wr) begin
         case (idx)
            sfir_pkg::REG_WIDTH:  width_ff   <= csr_pwdata[10:0];
            sfir_pkg::REG_HEIGHT: height_ff  <= csr_pwdata[10:0];
            sfir_pkg::REG_COEF0:  coef_ff[0] <= csr_pwdata[15:0];
            sfir_pkg::REG_COEF1:  coef_ff[1] <= csr_pwdata[15:0];
            sfir_pkg::REG_COEF2:  coef_ff[2] <= csr_pwdata[15:0];
            sfir_pkg::REG_COEF3:  coef_ff[3] <= csr_pwdata[15:0];
            sfir_pkg::REG_COEF4:  coef_ff[4] <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register reads, taps sign-extended
   always_comb begin
      case (idx)
         sfir_pkg::REG_WIDTH:  csr_prdata = 32'(width_ff);
         sfir_pkg::REG_HEIGHT: csr_prdata = 32'(height_ff);
         sfir_pkg::REG_COEF0:  csr_prdata = 32'($signed(coef_ff[0]));
         sfir_pkg::REG_COEF1:  csr_prdata = 32'($signed(coef_ff[1]));
         sfir_pkg::REG_COEF2:  csr_prdata = 32'($signed(coef_ff[2]));
         sfir_pkg::REG_COEF3:  csr_prdata = 32'($signed(coef_ff[3]));
         sfir_pkg::REG_COEF4:  csr_prdata = 32'($signed(coef_ff[4]));
         default:              csr_prdata = '0;
      endcase
   end

   // clamp the frame size into the supported range
   always_comb begin
      cfg.coef = coef_ff;
      if (PW'(width_ff) < PW'(TAPS))
         cfg.width = PW'(TAPS);
      else if (PW'(width_ff) > PW'(MAX_COLS))
         cfg.width = PW'(MAX_COLS);
      else
         cfg.width = PW'(width_ff);
      if (PW'(height_ff) < PW'(TAPS))
         cfg.height = PW'(TAPS);
      else if (PW'(height_ff) > PW'(MAX_ROWS))
         cfg.height = PW'(MAX_ROWS);
      else
         cfg.height = PW'(height_ff);
   end

   sfir_front #(
      .TAPS(TAPS), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)
   ) u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .pixel(req_tdata),
      .q_count(q_count), .push(push), .push_entry(push_entry)
   );

   sfir_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry),
      .pop(pop), .not_empty(not_empty), .head(head), .count(q_count)
   );

   sfir_back #(
      .TAPS(TAPS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .not_empty(not_empty), .head(head), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

endmodule
